@@ hdl/lz77wc_pkg.sv @@
// shared types and constants for the lz77 window copy decoder
package lz77wc_pkg;

    // longest match copied; longer requests are clamped to this
    localparam logic [9:0] MAX_MATCH = 10'd512;

    // token kinds
    localparam logic KIND_LITERAL = 1'b0;
    localparam logic KIND_MATCH   = 1'b1;

    // input token beat
    typedef struct packed {
        logic        kind;
        logic [7:0]  literal;
        logic [9:0]  match_length;
        logic [15:0] distance;
    } t_in_beat;

    // packed output word beat
    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last;
    } t_out_beat;

    // copy sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_WRITE = 3'b100
    } t_state;

endpackage

@@ hdl/lz77_window_copy_decoder.sv @@
// lz77 window copy decoder: history window, byte copy sequencer and word packer
//
//   channel | direction | handshake              | beat
//   --------+-----------+------------------------+----------------------------
//   in      | input     | i_in_valid / o_in_stall  | lz77wc_pkg::t_in_beat
//   out     | output    | o_out_valid / i_out_stall| lz77wc_pkg::t_out_beat
//
// a literal goes straight to the write state; a match passes through the read and write states once per byte
// the byte loop is the limit: one window memory port pair, read in the read state, written in the write state
// a match of length zero is accepted without leaving idle and gives no beat
// reset is synchronous, active low; the window itself is not cleared
// a stalled output holds its beat; the sequencer waits on a full output register when it has a word to push
module lz77_window_copy_decoder #(
    parameter int WINDOW_BITS = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  lz77wc_pkg::t_in_beat  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output lz77wc_pkg::t_out_beat o_out_data
);

    localparam int WIN_DEPTH = 1 << WINDOW_BITS;

    // history window
    logic [7:0] r_mem [WIN_DEPTH];

    lz77wc_pkg::t_state    r_state, n_state;
    logic [WINDOW_BITS-1:0] r_wp, n_wp;
    logic [9:0]             r_remain, n_remain;
    logic [2:0]             r_lane, n_lane;
    logic [63:0]            r_word, n_word;
    logic                   r_out_valid, n_out_valid;
    lz77wc_pkg::t_out_beat  r_out, n_out;
    logic [15:0]            r_dist;
    logic [7:0]             r_byte;

    logic                   in_accept;
    logic                   out_free;
    logic                   push;
    logic                   wr_go;
    logic [9:0]             len_clamped;
    logic [WINDOW_BITS-1:0] src_addr;
    logic [63:0]            packed_word;
    logic [5:0]             lane_bit;

    // handshake
    assign o_in_stall  = (r_state != lz77wc_pkg::ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    // byte step control
    assign push     = (r_lane == 3'd7) || (r_remain == 10'd1);
    assign wr_go    = (r_state == lz77wc_pkg::ST_WRITE) && (!push || out_free);
    assign src_addr = r_wp - WINDOW_BITS'(r_dist);
    assign lane_bit = {r_lane, 3'b000};

    // length clamp
    always_comb begin
        if (i_in_data.match_length > lz77wc_pkg::MAX_MATCH) begin
            len_clamped = lz77wc_pkg::MAX_MATCH;
        end else begin
            len_clamped = i_in_data.match_length;
        end
    end

    // insert current byte into the word being built
    always_comb begin
        packed_word = r_word;
        packed_word[lane_bit +: 8] = r_byte;
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_remain    = r_remain;
        n_lane      = r_lane;
        n_word      = r_word;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            lz77wc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (i_in_data.kind == lz77wc_pkg::KIND_LITERAL) begin
                        n_remain = 10'd1;
                        n_state  = lz77wc_pkg::ST_WRITE;
                    end else if (len_clamped != 10'd0) begin
                        n_remain = len_clamped;
                        n_state  = lz77wc_pkg::ST_READ;
                    end
                end
            end
            lz77wc_pkg::ST_READ: begin
                n_state = lz77wc_pkg::ST_WRITE;
            end
            lz77wc_pkg::ST_WRITE: begin
                if (wr_go) begin
                    n_wp     = r_wp + 1'b1;
                    n_remain = r_remain - 10'd1;
                    if (push) begin
                        n_out_valid      = 1'b1;
                        n_out.data_word  = packed_word;
                        n_out.byte_count = {1'b0, r_lane} + 4'd1;
                        n_out.last       = (r_remain == 10'd1);
                        n_word           = 64'd0;
                        n_lane           = 3'd0;
                    end else begin
                        n_word = packed_word;
                        n_lane = r_lane + 3'd1;
                    end
                    if (r_remain == 10'd1) begin
                        n_state = lz77wc_pkg::ST_IDLE;
                    end else begin
                        n_state = lz77wc_pkg::ST_READ;
                    end
                end
            end
            default: begin
                n_state = lz77wc_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lz77wc_pkg::ST_IDLE;
            r_wp        <= '0;
            r_remain    <= '0;
            r_lane      <= '0;
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_remain    <= n_remain;
            r_lane      <= n_lane;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // distance capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_dist <= i_in_data.distance;
        end
    end

    // window read or literal load
    always_ff @(posedge i_clk) begin
        if (r_state == lz77wc_pkg::ST_READ) begin
            r_byte <= r_mem[src_addr];
        end else if (in_accept) begin
            r_byte <= i_in_data.literal;
        end
    end

    // window write
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wp] <= r_byte;
        end
    end

endmodule

@@ hdl/lz77wc_checker.sv @@
// port checker for the lz77 window copy decoder, bound to the top level
module lz77wc_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input lz77wc_pkg::t_in_beat  i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input lz77wc_pkg::t_out_beat o_out_data
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // byte count in range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.byte_count != 4'd0) && (o_out_data.byte_count <= 4'd8))
        else $error("byte count out of range");

    // only the closing word of a token may be short
    a_full_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> o_out_data.byte_count == 4'd8)
        else $error("short word without last");

    // a token that produces bytes keeps the block busy next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall &&
        ((i_in_data.kind == lz77wc_pkg::KIND_LITERAL) || (i_in_data.match_length != 10'd0))
        |=> o_in_stall)
        else $error("accepted a token without going busy");

endmodule

bind lz77_window_copy_decoder lz77wc_checker u_lz77wc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ dv/testbench.sv @@
// self-checking testbench for the lz77 window copy decoder
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WIN_BITS     = 17;
    localparam int unsigned WIN_SIZE     = 1 << WIN_BITS;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          REPORT_MAX   = 10;

    logic                  i_clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    lz77wc_pkg::t_in_beat  in_token  = '0;
    logic                  out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    lz77wc_pkg::t_out_beat o_out_data;

    // shadow copy of the history window and its write pointer
    logic [7:0]          window_bytes [WIN_SIZE];
    logic [WIN_BITS-1:0] wr_pos        = '0;
    int unsigned         bytes_written = 0;

    // packed words still owed by the block, oldest first
    lz77wc_pkg::t_out_beat expected_words [$];
    int                    mismatch_count = 0;

    // idling knobs, in percent per beat or per cycle
    int gap_pct   = 0;
    int stall_pct = 0;

    lz77_window_copy_decoder #(
        .WINDOW_BITS (WIN_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_token),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop
    initial begin : watchdog
        #40ms;
        $display("FAILURE");
        $finish;
    end

    // store one decoded byte in the shadow window
    function automatic void store_byte(input logic [7:0] b);
        window_bytes[wr_pos] = b;
        wr_pos = wr_pos + 1'b1;
        if (bytes_written < WIN_SIZE) begin
            bytes_written++;
        end
    endfunction

    // decode one token and queue the words it must produce
    function automatic void predict_token(input lz77wc_pkg::t_in_beat tok);
        lz77wc_pkg::t_out_beat w;
        int unsigned           len;
        int unsigned           lane;
        logic [WIN_BITS-1:0]   src;
        logic [7:0]            b;
        w = '0;
        if (tok.kind == lz77wc_pkg::KIND_LITERAL) begin
            store_byte(tok.literal);
            w.data_word[7:0] = tok.literal;
            w.byte_count     = 4'd1;
            w.last           = 1'b1;
            expected_words.push_back(w);
            return;
        end
        len  = (tok.match_length > lz77wc_pkg::MAX_MATCH) ? lz77wc_pkg::MAX_MATCH
                                                          : tok.match_length;
        lane = 0;
        for (int unsigned i = 0; i < len; i++) begin
            // zero distance wraps to the entry at the write pointer itself
            src = wr_pos - WIN_BITS'(tok.distance);
            b   = window_bytes[src];
            store_byte(b);
            w.data_word[8*lane +: 8] = b;
            lane++;
            if (lane == 8 || i + 1 == len) begin
                w.byte_count = lane[3:0];
                w.last       = (i + 1 == len);
                expected_words.push_back(w);
                w    = '0;
                lane = 0;
            end
        end
    endfunction

    function automatic void note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endfunction

    function automatic lz77wc_pkg::t_in_beat make_literal(input logic [7:0] b);
        lz77wc_pkg::t_in_beat tok;
        tok.kind         = lz77wc_pkg::KIND_LITERAL;
        tok.literal      = b;
        tok.match_length = 10'($urandom_range(1023));
        tok.distance     = 16'($urandom_range(65535));
        return tok;
    endfunction

    function automatic lz77wc_pkg::t_in_beat make_match(input int unsigned len,
                                                        input int unsigned copy_dist);
        lz77wc_pkg::t_in_beat tok;
        tok.kind         = lz77wc_pkg::KIND_MATCH;
        tok.literal      = 8'($urandom_range(255));
        tok.match_length = len[9:0];
        tok.distance     = copy_dist[15:0];
        return tok;
    endfunction

    // random token that only reads history already written
    function automatic lz77wc_pkg::t_in_beat random_token();
        lz77wc_pkg::t_in_beat tok;
        int unsigned          pick;
        int unsigned          max_dist;
        int unsigned          len;
        int unsigned          copy_dist;
        if (bytes_written == 0 || $urandom_range(99) < 30) begin
            return make_literal(8'($urandom_range(255)));
        end
        pick = $urandom_range(99);
        if (pick < 4) begin
            len = 0;
        end else if (pick < 8) begin
            len = $urandom_range(1023, 513);
        end else if (pick < 14) begin
            len = $urandom_range(512, 65);
        end else if (pick < 40) begin
            len = $urandom_range(64, 17);
        end else begin
            len = $urandom_range(16, 1);
        end
        max_dist = (bytes_written > 65535) ? 65535 : bytes_written;
        pick     = $urandom_range(99);
        if (bytes_written >= WIN_SIZE && pick < 8) begin
            copy_dist = 0;
        end else if (pick < 45) begin
            // short distances give overlapping, repeating copies
            copy_dist = $urandom_range((max_dist < 8) ? max_dist : 8, 1);
        end else if (pick < 55) begin
            copy_dist = max_dist;
        end else begin
            copy_dist = $urandom_range(max_dist, 1);
        end
        tok = make_match(len, copy_dist);
        return tok;
    endfunction

    // send one token beat, with an occasional idle gap in front
    task automatic send_token(input lz77wc_pkg::t_in_beat tok);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_token <= tok;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_token(tok);
    endtask

    // hold the input idle until every owed word has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        lz77wc_pkg::t_in_beat tok;
        int                   sent;
        sent = 0;
        while (sent < n) begin
            tok = random_token();
            send_token(tok);
            if (!(tok.kind == lz77wc_pkg::KIND_MATCH && tok.match_length == 0)) begin
                sent++;
            end
        end
    endtask

    // literal extremes, with junk in the unused fields
    task automatic test_literals();
        lz77wc_pkg::t_in_beat tok;
        gap_pct   = 25;
        stall_pct = 20;
        send_token(make_literal(8'h00));
        send_token(make_literal(8'hff));
        tok              = make_literal(8'h55);
        tok.match_length = 10'h3ff;
        tok.distance     = 16'hffff;
        send_token(tok);
        tok              = make_literal(8'haa);
        tok.match_length = '0;
        tok.distance     = '0;
        send_token(tok);
        send_token(make_literal(8'h01));
        send_token(make_literal(8'h80));
        send_token(make_literal(8'h7f));
        send_token(make_literal(8'($urandom_range(255))));
    endtask

    // match word shapes: single byte, exact words, overlap, zero length, clamp
    task automatic test_match_shapes();
        gap_pct   = 20;
        stall_pct = 30;
        send_token(make_match(1, 1));
        send_token(make_match(8, 8));
        send_token(make_match(9, 3));
        send_token(make_match(0, 5));
        send_token(make_match(16, 2));
        wait_drained();
        send_token(make_match(1023, 1));
        send_token(make_match(512, 100));
        send_token(make_match(7, bytes_written));
        send_token(make_match(513, 17));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        gap_pct   = 30;
        stall_pct = 30;
        run_random(50);
        // a stretch without idling
        gap_pct   = 0;
        stall_pct = 0;
        run_random(40);
        gap_pct   = 10;
        stall_pct = 50;
        run_random(50);
    endtask

    // fill the whole window, then copy across the wrap and from a full window back
    task automatic test_window_wrap();
        int unsigned max_dist;
        gap_pct   = 15;
        stall_pct = 15;
        while (bytes_written < WIN_SIZE) begin
            max_dist = (bytes_written > 65535) ? 65535 : bytes_written;
            if ($urandom_range(15) == 0) begin
                send_token(make_literal(8'($urandom_range(255))));
            end else begin
                send_token(make_match(512, $urandom_range(max_dist, 1)));
            end
        end
        send_token(make_match(1, 0));
        send_token(make_match(20, 0));
        send_token(make_match(512, 65535));
        send_token(make_match(3, 65535));
        send_token(make_literal(8'hff));
        send_token(make_match(1023, 0));
        wait_drained();
    endtask

    // closing stretch at full rate on both sides
    task automatic test_streaming();
        gap_pct   = 0;
        stall_pct = 0;
        run_random(40);
    endtask

    // output back-pressure in random bursts
    initial begin : stall_gen
        int n;
        forever begin
            @(posedge i_clk);
            if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                n = $urandom_range(6, 1);
                out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // compare each accepted output beat with the oldest owed word
    always @(posedge i_clk) begin : check_beat
        lz77wc_pkg::t_out_beat want;
        if (rst_n && o_out_valid === 1'b1 && out_stall == 1'b0) begin
            if (expected_words.size() == 0) begin
                note_error($sformatf("unexpected beat data %h count %0d last %0d",
                    o_out_data.data_word, o_out_data.byte_count, o_out_data.last));
            end else begin
                want = expected_words.pop_front();
                if (o_out_data.data_word !== want.data_word) begin
                    note_error($sformatf("data_word expected %h got %h",
                        want.data_word, o_out_data.data_word));
                end
                if (o_out_data.byte_count !== want.byte_count) begin
                    note_error($sformatf("byte_count expected %0d got %0d",
                        want.byte_count, o_out_data.byte_count));
                end
                if (o_out_data.last !== want.last) begin
                    note_error($sformatf("last expected %0d got %0d",
                        want.last, o_out_data.last));
                end
            end
        end
    end

    // main sequence
    initial begin
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_literals();
        test_match_shapes();
        test_random_traffic();
        test_window_wrap();
        test_streaming();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
